// ===== design/tfb_pkg.sv =====
// Shared constants, byte positions and the CRC-16 byte update for the frame builder.
`default_nettype none

package tfb_pkg;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;

    localparam logic [PADDR_W-3:0] REG_VERSION = 1'b0;

    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    localparam logic [7:0]  SYNC_FIRST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND = 8'h55;
    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;

    typedef logic [4:0] t_byte_pos;

    localparam t_byte_pos POS_SYNC0   = 5'd0;
    localparam t_byte_pos POS_SYNC1   = 5'd1;
    localparam t_byte_pos POS_VERSION = 5'd2;
    localparam t_byte_pos POS_COMMAND = 5'd3;
    localparam t_byte_pos POS_FLAGS   = 5'd4;
    localparam t_byte_pos POS_LEN_LO  = 5'd5;
    localparam t_byte_pos POS_LEN_HI  = 5'd6;
    localparam t_byte_pos POS_SEQ0    = 5'd7;
    localparam t_byte_pos POS_SEQ1    = 5'd8;
    localparam t_byte_pos POS_SEQ2    = 5'd9;
    localparam t_byte_pos POS_SEQ3    = 5'd10;
    localparam t_byte_pos POS_TIME0   = 5'd11;
    localparam t_byte_pos POS_TIME1   = 5'd12;
    localparam t_byte_pos POS_TIME2   = 5'd13;
    localparam t_byte_pos POS_TIME3   = 5'd14;
    localparam t_byte_pos POS_CRC_LO  = 5'd15;
    localparam t_byte_pos POS_CRC_HI  = 5'd16;

    localparam t_byte_pos PAY_DATA    = 5'd0;
    localparam t_byte_pos PAY_CRC_LO  = 5'd1;
    localparam t_byte_pos PAY_CRC_HI  = 5'd2;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/tfb_if.sv =====
// Valid/ready channel interfaces for frame builder items and serialized bytes.
`default_nettype none

interface tfb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  command;
    logic [7:0]  frame_flags;
    logic [15:0] length;
    logic [31:0] sequence_req;
    logic [31:0] time_ms;
    logic [7:0]  payload_byte;

    modport source (
        output valid, action, command, frame_flags, length, sequence_req, time_ms,
               payload_byte,
        input  ready
    );
    modport sink (
        input  valid, action, command, frame_flags, length, sequence_req, time_ms,
               payload_byte,
        output ready
    );
endinterface

interface tfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, out_byte, last, input ready);
    modport sink (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== design/tlv_frame_builder_crc16_top.sv =====
// Frame builder top level: header serializer, payload pass-through and CRC-16 trailer.
// Accepted items are registered, then serialized; a new item is taken as the last byte is emitted.
// A payload byte goes out alone, or is followed by the CRC low and high bytes if it closes the
// frame; a start item emits the sync and header bytes, plus the CRC trailer if its length is
// zero. A stray payload byte is dropped. Bytes go out one per cycle unless the output stalls.
// Reset is synchronous and active low; it closes any frame, presets the CRC and clears version.
`default_nettype none

module tlv_frame_builder_crc16_top import tfb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tfb_in_if.sink                  i_in,
    tfb_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic [7:0]  r_version;
    logic        r_busy;
    t_byte_pos   r_idx;
    logic        r_in_frame;
    logic [15:0] r_bytes_left;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        r_action;
    logic [7:0]  r_command;
    logic [7:0]  r_flags;
    logic [15:0] r_length;
    logic [31:0] r_seq;
    logic [31:0] r_time;
    logic [7:0]  r_payload;

    logic        cfg_write;
    logic        in_fire;
    logic        out_free;
    logic        drop;
    logic        emit;
    logic [7:0]  n_out_byte;
    logic        n_out_last;
    logic        crc_feed;
    logic        item_end;
    logic [15:0] n_crc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[PADDR_W-1:2] == REG_VERSION);
    assign prdata    = (paddr[PADDR_W-1:2] == REG_VERSION)
                       ? {{(PDATA_W-8){1'b0}}, r_version} : '0;

    assign out_free  = !r_out_valid || o_out.ready;
    assign drop      = r_busy && (r_action == ACT_PAYLOAD) && (r_idx == PAY_DATA) && !r_in_frame;
    assign emit      = r_busy && !drop && out_free;
    assign i_in.ready = !r_busy || (emit && item_end) || drop;
    assign in_fire   = i_in.valid && i_in.ready;

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.last     = r_out_last;

    always_comb begin
        n_out_byte = '0;
        n_out_last = 1'b0;
        crc_feed   = 1'b0;
        item_end   = 1'b0;
        if (r_action == ACT_START) begin
            crc_feed = (r_idx >= POS_VERSION) && (r_idx <= POS_TIME3);
            item_end = ((r_idx == POS_TIME3) && (r_length != 16'd0)) || (r_idx == POS_CRC_HI);
            case (r_idx)
                POS_SYNC0:   n_out_byte = SYNC_FIRST;
                POS_SYNC1:   n_out_byte = SYNC_SECOND;
                POS_VERSION: n_out_byte = r_version;
                POS_COMMAND: n_out_byte = r_command;
                POS_FLAGS:   n_out_byte = r_flags;
                POS_LEN_LO:  n_out_byte = r_length[7:0];
                POS_LEN_HI:  n_out_byte = r_length[15:8];
                POS_SEQ0:    n_out_byte = r_seq[7:0];
                POS_SEQ1:    n_out_byte = r_seq[15:8];
                POS_SEQ2:    n_out_byte = r_seq[23:16];
                POS_SEQ3:    n_out_byte = r_seq[31:24];
                POS_TIME0:   n_out_byte = r_time[7:0];
                POS_TIME1:   n_out_byte = r_time[15:8];
                POS_TIME2:   n_out_byte = r_time[23:16];
                POS_TIME3:   n_out_byte = r_time[31:24];
                POS_CRC_LO:  n_out_byte = r_crc[7:0];
                POS_CRC_HI: begin
                    n_out_byte = r_crc[15:8];
                    n_out_last = 1'b1;
                end
                default:     n_out_byte = '0;
            endcase
        end else begin
            case (r_idx)
                PAY_DATA: begin
                    n_out_byte = r_payload;
                    crc_feed   = 1'b1;
                    item_end   = (r_bytes_left != 16'd1);
                end
                PAY_CRC_LO:  n_out_byte = r_crc[7:0];
                PAY_CRC_HI: begin
                    n_out_byte = r_crc[15:8];
                    n_out_last = 1'b1;
                    item_end   = 1'b1;
                end
                default:     n_out_byte = '0;
            endcase
        end
    end

    assign n_crc = crc16_byte(r_crc, n_out_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_version    <= '0;
            r_busy       <= 1'b0;
            r_idx        <= '0;
            r_in_frame   <= 1'b0;
            r_bytes_left <= '0;
            r_crc        <= CRC_INIT;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_write) begin
                r_version <= pwdata[7:0];
            end

            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            if (emit) begin
                r_idx <= item_end ? '0 : r_idx + 5'd1;
                if ((r_action == ACT_START) && (r_idx == POS_SYNC0)) begin
                    r_crc        <= CRC_INIT;
                    r_in_frame   <= 1'b1;
                    r_bytes_left <= r_length;
                end
                if (crc_feed) begin
                    r_crc <= n_crc;
                end
                if ((r_action == ACT_PAYLOAD) && (r_idx == PAY_DATA)) begin
                    r_bytes_left <= r_bytes_left - 16'd1;
                end
                if (n_out_last) begin
                    r_in_frame   <= 1'b0;
                    r_bytes_left <= '0;
                    r_crc        <= CRC_INIT;
                end
            end

            if (in_fire) begin
                r_busy <= 1'b1;
            end else if ((emit && item_end) || drop) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action  <= i_in.action;
            r_command <= i_in.command;
            r_flags   <= i_in.frame_flags;
            r_length  <= i_in.length;
            r_seq     <= i_in.sequence_req;
            r_time    <= i_in.time_ms;
            r_payload <= i_in.payload_byte;
        end
        if (emit) begin
            r_out_byte <= n_out_byte;
            r_out_last <= n_out_last;
        end
    end

endmodule

`default_nettype wire

// ===== design/tfb_checker.sv =====
// Port-level checker for the frame builder top level and its bind statement.
`default_nettype none

module tfb_checker import tfb_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [7:0]         i_out_byte,
    input wire logic               i_out_last,
    input wire logic               i_psel,
    input wire logic               i_penable,
    input wire logic               i_pwrite,
    input wire logic [PADDR_W-1:0] i_paddr,
    input wire logic [PDATA_W-1:0] i_pwdata,
    input wire logic [PDATA_W-1:0] i_prdata,
    input wire logic               i_pready
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stalled_output_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_out_last))
        else $error("stalled output transaction changed");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("pready dropped");

    a_version_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && i_pready && (i_paddr[PADDR_W-1:2] == REG_VERSION)
        |=> (i_paddr[PADDR_W-1:2] != REG_VERSION) || (i_prdata[7:0] == $past(i_pwdata[7:0])))
        else $error("version register does not read back the written value");

endmodule

bind tlv_frame_builder_crc16_top tfb_checker u_tfb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.last),
    .i_psel      (psel),
    .i_penable   (penable),
    .i_pwrite    (pwrite),
    .i_paddr     (paddr),
    .i_pwdata    (pwdata),
    .i_prdata    (prdata),
    .i_pready    (pready)
);

`default_nettype wire

// ===== verif/tlv_frame_builder_crc16_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the frame builder: header, payload and CRC-16 trailer bytes.

module tlv_frame_builder_crc16_top_test;
    import tfb_pkg::*;

    localparam int unsigned MAX_WAIT = 14;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RANDOM_PHASE_ITEMS = 115;
    localparam logic [PADDR_W-1:0] VERSION_ADDR = {REG_VERSION, 2'b00};

    typedef struct packed {
        logic        action;
        logic [7:0]  command;
        logic [7:0]  frame_flags;
        logic [15:0] length;
        logic [31:0] sequence_req;
        logic [31:0] time_ms;
        logic [7:0]  payload_byte;
    } t_frame_item;

    typedef struct packed {
        logic [7:0] value;
        logic       ends_frame;
    } t_frame_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    tfb_in_if  in_ch ();
    tfb_out_if out_ch ();

    tlv_frame_builder_crc16_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [7:0]  version_reg;
    logic        frame_open;
    logic [15:0] bytes_remaining;
    logic [15:0] crc_acc;
    t_frame_byte pending_bytes[$];

    int error_count = 0;
    int counted_items = 0;
    int frames_started = 0;
    int payload_bytes = 0;
    int stray_bytes = 0;
    int checked_bytes = 0;
    int version_writes = 0;
    bit in_steady = 1'b0;
    bit rx_steady = 1'b0;

    always #10 i_clk = ~i_clk;

    function automatic logic [15:0] crc_ccitt_next(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] r;
        logic        fb;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[15] ^ d[i];
            r = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return r;
    endfunction

    function automatic t_frame_item build_start(input logic [7:0] cmd, input logic [7:0] flags,
                                                input logic [15:0] len, input logic [31:0] seq,
                                                input logic [31:0] tms);
        t_frame_item it;
        it.action       = ACT_START;
        it.command      = cmd;
        it.frame_flags  = flags;
        it.length       = len;
        it.sequence_req = seq;
        it.time_ms      = tms;
        it.payload_byte = 8'($urandom);
        return it;
    endfunction

    function automatic t_frame_item build_payload(input logic [7:0] data);
        t_frame_item it;
        it.action       = ACT_PAYLOAD;
        it.command      = 8'($urandom);
        it.frame_flags  = 8'($urandom);
        it.length       = 16'($urandom);
        it.sequence_req = $urandom;
        it.time_ms      = $urandom;
        it.payload_byte = data;
        return it;
    endfunction

    task automatic expect_plain(input logic [7:0] value, input logic ends_frame);
        t_frame_byte b;
        b.value      = value;
        b.ends_frame = ends_frame;
        pending_bytes.insert(pending_bytes.size(), b);
    endtask

    task automatic expect_covered(input logic [7:0] value);
        crc_acc = crc_ccitt_next(crc_acc, value);
        expect_plain(value, 1'b0);
    endtask

    task automatic expect_trailer();
        expect_plain(crc_acc[7:0], 1'b0);
        expect_plain(crc_acc[15:8], 1'b1);
        frame_open      = 1'b0;
        bytes_remaining = 16'h0000;
        crc_acc         = CRC_INIT;
    endtask

    task automatic predict_frame_bytes(input t_frame_item it);
        if (it.action == ACT_START) begin
            crc_acc = CRC_INIT;
            expect_plain(SYNC_FIRST, 1'b0);
            expect_plain(SYNC_SECOND, 1'b0);
            expect_covered(version_reg);
            expect_covered(it.command);
            expect_covered(it.frame_flags);
            expect_covered(it.length[7:0]);
            expect_covered(it.length[15:8]);
            for (int k = 0; k < 4; k++) expect_covered(it.sequence_req[8*k +: 8]);
            for (int k = 0; k < 4; k++) expect_covered(it.time_ms[8*k +: 8]);
            frame_open      = 1'b1;
            bytes_remaining = it.length;
            frames_started++;
            counted_items++;
            if (bytes_remaining == 16'h0000) expect_trailer();
        end else if (frame_open) begin
            expect_covered(it.payload_byte);
            bytes_remaining = bytes_remaining - 16'd1;
            payload_bytes++;
            counted_items++;
            if (bytes_remaining == 16'h0000) expect_trailer();
        end else begin
            stray_bytes++;
        end
    endtask

    task automatic send_item(input t_frame_item it);
        int gap;
        gap = in_steady ? 0 : $urandom_range(0, MAX_WAIT);
        repeat (gap) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        in_ch.valid        <= 1'b1;
        in_ch.action       <= it.action;
        in_ch.command      <= it.command;
        in_ch.frame_flags  <= it.frame_flags;
        in_ch.length       <= it.length;
        in_ch.sequence_req <= it.sequence_req;
        in_ch.time_ms      <= it.time_ms;
        in_ch.payload_byte <= it.payload_byte;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_frame_bytes(it);
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_check_version();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= VERSION_ADDR;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== PDATA_W'(version_reg)) begin
            $display("%0t: version readback mismatch: expected %08h, got %08h",
                     $time, PDATA_W'(version_reg), prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_write_version(input logic [7:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= VERSION_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        version_reg = value;
        version_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apb_check_version();
    endtask

    task automatic test_reset_version();
        apb_check_version();
        send_item(build_start(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000));
        wait_for_drain();
    endtask

    task automatic test_header_extremes();
        apb_write_version(8'hFF);
        send_item(build_start(8'h00, 8'h00, 16'h0000, 32'h0000_0000, 32'h0000_0000));
        send_item(build_start(8'hFF, 8'hFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(build_start(8'h3C, 8'hC3, 16'h0001, 32'h1234_5678, 32'h8765_4321));
        send_item(build_payload(8'hFF));
        wait_for_drain();
    endtask

    task automatic test_stray_payload();
        send_item(build_payload(8'h00));
        send_item(build_payload(8'hFF));
        send_item(build_start(8'h5A, 8'hA5, 16'h0002, 32'h0000_0001, 32'h8000_0000));
        send_item(build_payload(8'h00));
        send_item(build_payload(8'h5A));
        send_item(build_payload(8'hFF));
        wait_for_drain();
    endtask

    task automatic test_abandoned_frame();
        apb_write_version(8'h00);
        send_item(build_start(8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(build_payload(8'hFF));
        send_item(build_payload(8'h00));
        send_item(build_start(8'h81, 8'h18, 16'h0003, $urandom, $urandom));
        repeat (3) send_item(build_payload(8'($urandom)));
        wait_for_drain();
    endtask

    task automatic run_random_frames(input int target);
        int          goal;
        int          kind;
        int          to_send;
        t_frame_item it;
        goal = counted_items + target;
        while (counted_items < goal) begin
            in_steady = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_item(build_payload(8'($urandom)));
            end else begin
                if (kind == 1) begin
                    it = build_start(8'($urandom), 8'($urandom), 16'($urandom), $urandom, $urandom);
                end else if (kind <= 3) begin
                    it = build_start(8'($urandom), 8'($urandom), 16'($urandom_range(0, 40)),
                                     $urandom, $urandom);
                end else begin
                    it = build_start(8'($urandom), 8'($urandom), 16'($urandom_range(0, 8)),
                                     $urandom, $urandom);
                end
                send_item(it);
                to_send = it.length;
                if (kind <= 2) to_send = $urandom_range(0, (it.length < 6) ? it.length : 5);
                repeat (to_send) send_item(build_payload(8'($urandom)));
            end
        end
        in_steady = 1'b0;
    endtask

    task automatic test_random_traffic();
        run_random_frames(RANDOM_PHASE_ITEMS);
        wait_for_drain();
        apb_write_version(8'hFF);
        run_random_frames(RANDOM_PHASE_ITEMS);
        wait_for_drain();
        apb_write_version(8'($urandom));
        run_random_frames(RANDOM_PHASE_ITEMS);
        wait_for_drain();
        apb_write_version(8'h00);
        run_random_frames(RANDOM_PHASE_ITEMS);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_START;
        in_ch.command      = 8'h00;
        in_ch.frame_flags  = 8'h00;
        in_ch.length       = 16'h0000;
        in_ch.sequence_req = 32'h0000_0000;
        in_ch.time_ms      = 32'h0000_0000;
        in_ch.payload_byte = 8'h00;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        version_reg        = 8'h00;
        frame_open         = 1'b0;
        bytes_remaining    = 16'h0000;
        crc_acc            = CRC_INIT;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_version();
        test_header_extremes();
        test_stray_payload();
        test_abandoned_frame();
        test_random_traffic();
        wait_for_drain();

        $display("Run covered %0d frames, %0d framed payload bytes and %0d dropped stray bytes.",
                 frames_started, payload_bytes, stray_bytes);
        $display("%0d output bytes were checked across %0d version register writes.",
                 checked_bytes, version_writes);
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        int stall;
        out_ch.ready = 1'b0;
        forever begin
            if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            repeat (stall) begin
                @(negedge i_clk);
                out_ch.ready <= 1'b0;
            end
            @(negedge i_clk);
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin : check_output
        t_frame_byte want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected output byte: expected none, got %02h last %0b",
                         $time, out_ch.out_byte, out_ch.last);
                error_count++;
            end else begin
                want = pending_bytes.pop_front();
                checked_bytes++;
                if (out_ch.out_byte !== want.value) begin
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, want.value, out_ch.out_byte);
                    error_count++;
                end
                if (out_ch.last !== want.ends_frame) begin
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, want.ends_frame, out_ch.last);
                    error_count++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Timed out with %0d output bytes still expected.", pending_bytes.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
